@@ src/cpsp_pkg.sv @@
// Shared types, constants and result layout for the command packet stream parser.
package cpsp_pkg;

    // Width of the word offset counters inside a buffer.
    localparam int OFFSET_BITS = 16;

    typedef logic [OFFSET_BITS-1:0] t_offset;

    // Header layout.
    localparam logic [1:0] TYPE3 = 2'b11;

    // Per-opcode minimum payload words.
    localparam logic [2:0] MIN_NONE = 3'd0;
    localparam logic [2:0] MIN_TWO  = 3'd2;
    localparam logic [2:0] MIN_FOUR = 3'd4;

    // Register reset values.
    localparam logic [7:0] RST_SET_SH       = 8'd118;
    localparam logic [7:0] RST_SET_CONTEXT  = 8'd105;
    localparam logic [7:0] RST_SET_UCONFIG  = 8'd121;
    localparam logic [7:0] RST_DISPATCH_DIR = 8'd21;
    localparam logic [7:0] RST_DRAW_IDX     = 8'd45;

    typedef enum logic [2:0] {
        REG_SET_SH          = 3'd0,
        REG_SET_CONTEXT     = 3'd1,
        REG_SET_UCONFIG     = 3'd2,
        REG_DISPATCH_DIRECT = 3'd3,
        REG_DRAW_INDEX_AUTO = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_PKT  = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TYPE      = 2'd1,
        ERR_TRUNCATED = 2'd2,
        ERR_SHORT     = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] set_sh;
        logic [7:0] set_context;
        logic [7:0] set_uconfig;
        logic [7:0] dispatch_direct;
        logic [7:0] draw_index_auto;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [31:0] header_value;
        logic [7:0]  packet_opcode;
        logic [15:0] header_position;
        logic [15:0] packet_number;
        logic [14:0] payload_length;
        logic [15:0] available_length;
        logic [15:0] consumed_words;
    } t_result;

endpackage

@@ src/cpsp_regs.sv @@
// APB register file holding the five opcode match registers.
module cpsp_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cpsp_pkg::t_cfg     o_cfg
);

    cpsp_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_sh          <= cpsp_pkg::RST_SET_SH;
            r_cfg.set_context     <= cpsp_pkg::RST_SET_CONTEXT;
            r_cfg.set_uconfig     <= cpsp_pkg::RST_SET_UCONFIG;
            r_cfg.dispatch_direct <= cpsp_pkg::RST_DISPATCH_DIR;
            r_cfg.draw_index_auto <= cpsp_pkg::RST_DRAW_IDX;
        end else if (w_wr) begin
            case (w_idx)
                cpsp_pkg::REG_SET_SH:          r_cfg.set_sh          <= pwdata[7:0];
                cpsp_pkg::REG_SET_CONTEXT:     r_cfg.set_context     <= pwdata[7:0];
                cpsp_pkg::REG_SET_UCONFIG:     r_cfg.set_uconfig     <= pwdata[7:0];
                cpsp_pkg::REG_DISPATCH_DIRECT: r_cfg.dispatch_direct <= pwdata[7:0];
                cpsp_pkg::REG_DRAW_INDEX_AUTO: r_cfg.draw_index_auto <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cpsp_pkg::REG_SET_SH:          prdata = {24'd0, r_cfg.set_sh};
            cpsp_pkg::REG_SET_CONTEXT:     prdata = {24'd0, r_cfg.set_context};
            cpsp_pkg::REG_SET_UCONFIG:     prdata = {24'd0, r_cfg.set_uconfig};
            cpsp_pkg::REG_DISPATCH_DIRECT: prdata = {24'd0, r_cfg.dispatch_direct};
            cpsp_pkg::REG_DRAW_INDEX_AUTO: prdata = {24'd0, r_cfg.draw_index_auto};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

@@ src/cpsp_core.sv @@
// Buffer tracking state and the per-word header check.
module cpsp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [31:0]         i_word,
    input  logic                i_start,
    input  logic [15:0]         i_len,
    input  cpsp_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output cpsp_pkg::t_result   o_res
);

    cpsp_pkg::t_offset r_pos, r_tw, r_ps;
    logic [14:0]       r_pl;
    logic              r_failed;

    cpsp_pkg::t_offset n_pos, n_tw, n_ps;
    logic [14:0]       n_pl;
    logic              n_failed;

    cpsp_pkg::t_offset e_pos, e_tw, e_ps;
    logic [14:0]       e_pl;
    logic              e_failed;

    cpsp_pkg::t_offset w_avail;
    logic [14:0]       w_payload;
    logic [7:0]        w_op;
    logic [2:0]        w_min;
    logic              w_last;

    // Minimum payload per opcode; direct dispatch wins when registers alias.
    always_comb begin
        if (w_op == i_cfg.dispatch_direct) begin
            w_min = cpsp_pkg::MIN_FOUR;
        end else if (w_op == i_cfg.set_sh || w_op == i_cfg.set_context ||
                     w_op == i_cfg.set_uconfig || w_op == i_cfg.draw_index_auto) begin
            w_min = cpsp_pkg::MIN_TWO;
        end else begin
            w_min = cpsp_pkg::MIN_NONE;
        end
    end

    assign w_op      = i_word[15:8];
    assign w_payload = {1'b0, i_word[29:16]} + 15'd1;

    always_comb begin
        e_tw     = r_tw;
        e_pos    = r_pos;
        e_pl     = r_pl;
        e_ps     = r_ps;
        e_failed = r_failed;
        if (i_start) begin
            e_tw     = cpsp_pkg::t_offset'(i_len);
            e_pos    = '0;
            e_pl     = '0;
            e_ps     = '0;
            e_failed = 1'b0;
        end
        w_avail = e_tw - e_pos - cpsp_pkg::t_offset'(1);
        w_last  = (e_pos + cpsp_pkg::t_offset'(1)) == e_tw;

        n_tw        = e_tw;
        n_pos       = e_pos;
        n_pl        = e_pl;
        n_ps        = e_ps;
        n_failed    = e_failed;
        o_res       = '0;
        o_res_valid = 1'b0;

        if (i_start && e_tw == '0) begin
            // empty buffer: done at once
            o_res_valid = 1'b1;
            o_res.kind  = cpsp_pkg::KIND_DONE;
        end else if (!e_failed && e_pos < e_tw) begin
            n_pos = e_pos + cpsp_pkg::t_offset'(1);
            if (e_pl != '0) begin
                n_pl = e_pl - 15'd1;
                if (w_last) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = cpsp_pkg::KIND_DONE;
                    o_res.packet_number  = 16'(e_ps);
                    o_res.consumed_words = 16'(e_tw);
                end
            end else begin
                o_res_valid           = 1'b1;
                o_res.header_value    = i_word;
                o_res.packet_opcode   = w_op;
                o_res.header_position = 16'(e_pos);
                o_res.packet_number   = 16'(e_ps);
                if (i_word[31:30] != cpsp_pkg::TYPE3) begin
                    n_failed             = 1'b1;
                    o_res.kind           = cpsp_pkg::KIND_ERR;
                    o_res.err            = cpsp_pkg::ERR_TYPE;
                    o_res.consumed_words = 16'(e_pos);
                end else if (16'(w_payload) > 16'(w_avail)) begin
                    n_failed               = 1'b1;
                    o_res.kind             = cpsp_pkg::KIND_ERR;
                    o_res.err              = cpsp_pkg::ERR_TRUNCATED;
                    o_res.payload_length   = w_payload;
                    o_res.available_length = 16'(w_avail);
                    o_res.consumed_words   = 16'(e_pos);
                end else if (w_payload < 15'(w_min)) begin
                    n_failed               = 1'b1;
                    o_res.kind             = cpsp_pkg::KIND_ERR;
                    o_res.err              = cpsp_pkg::ERR_SHORT;
                    o_res.payload_length   = 15'(w_min);
                    o_res.available_length = 16'(w_payload);
                    o_res.consumed_words   = 16'(e_pos);
                end else begin
                    o_res.kind             = cpsp_pkg::KIND_PKT;
                    o_res.payload_length   = w_payload;
                    o_res.available_length = 16'(w_avail);
                    n_pl                   = w_payload;
                    n_ps                   = e_ps + cpsp_pkg::t_offset'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_tw     <= '0;
            r_pl     <= '0;
            r_ps     <= '0;
            r_failed <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_tw     <= n_tw;
            r_pl     <= n_pl;
            r_ps     <= n_ps;
            r_failed <= n_failed;
        end
    end

endmodule

@@ src/command_packet_stream_parser.sv @@
// Top level: input register, header check core, result register and APB registers.
//
// Channel   Dir  Handshake              Contents
// s_axis    in   tvalid/tready          tdata: stream_word, buffer_length; tuser: buffer_start
// m_axis    out  tvalid/tready          tdata: descriptor/error/done fields; tuser: result_kind
// apb       in   psel/penable/pready    five 8-bit opcode registers at 4*i
//
// Flow: one request per clock sustained while m_axis does not stall; a word is registered
// at acceptance, checked from the input register, and its result (if any) is registered
// for m_axis. The single compare/subtract stage lies between the input and result registers.
// Reset: synchronous, active low; clears buffer state, valids and restores the
// register defaults. No clearing pass.
// Stalls: the input register keeps taking requests while a result waits, until both
// the input register and result register are full.
module command_packet_stream_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // [31:0] stream_word, [47:32] buffer_length
    input  logic         s_axis_tuser,   // [0] buffer_start
    // results out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [1:0] error_code, [33:2] header_value,
                                         // [41:34] packet_opcode, [57:42] header_position,
                                         // [73:58] packet_number, [88:74] payload_length,
                                         // [104:89] available_length,
                                         // [120:105] consumed_words, [127:121] zero
    output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cpsp_pkg::t_cfg    w_cfg;
    cpsp_pkg::t_result w_res;
    cpsp_pkg::t_result r_out;
    logic              w_res_valid;
    logic              w_fire;

    // input register
    logic              r_in_valid;
    logic [31:0]       r_in_word;
    logic              r_in_start;
    logic [15:0]       r_in_len;
    logic              r_out_valid;

    cpsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held word is processed when the result register is free or being drained.
    assign w_fire        = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_fire;

    cpsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_word      (r_in_word),
        .i_start     (r_in_start),
        .i_len       (r_in_len),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word  <= s_axis_tdata[31:0];
            r_in_len   <= s_axis_tdata[47:32];
            r_in_start <= s_axis_tuser;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {7'd0,
                            r_out.consumed_words,
                            r_out.available_length,
                            r_out.payload_length,
                            r_out.packet_number,
                            r_out.header_position,
                            r_out.packet_opcode,
                            r_out.header_value,
                            r_out.err};

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == cpsp_pkg::KIND_DONE |-> r_out.err == cpsp_pkg::ERR_NONE)
        else $error("done result carries an error code");

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == cpsp_pkg::KIND_ERR |-> r_out.err != cpsp_pkg::ERR_NONE)
        else $error("error result without a code");

    a_pkt_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == cpsp_pkg::KIND_PKT |->
            r_out.consumed_words == 16'd0 && r_out.payload_length != 15'd0)
        else $error("descriptor with bad consumed or payload fields");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("pending result lost or changed");

endmodule

@@ bench/tb_command_packet_stream_parser.sv @@
// Self-checking bench for the command packet stream parser: stream traffic, APB config, scoreboard.
module tb_command_packet_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import cpsp_pkg::*;

    // Cycles to let a word with no result clear the input and result registers.
    localparam int DRAIN_CYCLES   = 8;
    // Length of the forced receiver hold-off, in cycles.
    localparam int LONG_HOLD      = 300;
    // Cycles with no request of any kind before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 150;

    // Ways a generated buffer can go wrong.
    typedef enum int {
        FLAW_NONE,
        FLAW_TYPE,   // last packet has a non type-3 header
        FLAW_TRUNC,  // last packet's count runs past the buffer end
        FLAW_SHORT,  // last packet is below its opcode minimum
        FLAW_CUT,    // buffer dropped partway by the next start word
        FLAW_EXTRA   // stray words after the buffer end
    } t_flaw;

    typedef struct {
        logic [31:0] word;
        bit          start;
        logic [15:0] len;
    } t_stream_word;

    logic         i_clk;
    logic         i_rst_n        = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata   = '0;    // [31:0] stream_word, [47:32] buffer_length
    logic         s_axis_tuser   = 1'b0;  // [0] buffer_start
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [127:0] m_axis_tdata;           // [1:0] error_code ... [120:105] consumed_words
    logic [1:0]   m_axis_tuser;           // [1:0] result_kind
    logic         psel           = 1'b0;
    logic         penable        = 1'b0;
    logic         pwrite         = 1'b0;
    logic [4:0]   paddr          = '0;
    logic [31:0]  pwdata         = '0;
    logic [31:0]  prdata;
    logic         pready;

    command_packet_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Stimulus and traffic controls; changed by the sequence only at the falling edge.
    t_stream_word pending_words[$];
    int           words_queued   = 0;
    int           send_idle_pct  = 0;
    int           stall_pct      = 0;
    int           long_hold_req  = 0;

    // Parser shadow: opcode registers and buffer walk state.
    t_cfg         opcode_cfg;
    t_offset      cur_pos;
    t_offset      buf_words;
    logic [14:0]  skip_left;
    logic [15:0]  pkt_count;
    bit           buf_failed;

    t_result      expected_results[$];
    int           fault_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------

    // Minimum payload for an opcode; the dispatch check comes first so the
    // larger minimum wins when registers hold the same value.
    function automatic int required_payload(input logic [7:0] op);
        if (op == opcode_cfg.dispatch_direct)
            return MIN_FOUR;
        if (op == opcode_cfg.set_sh || op == opcode_cfg.set_context ||
            op == opcode_cfg.set_uconfig || op == opcode_cfg.draw_index_auto)
            return MIN_TWO;
        return MIN_NONE;
    endfunction

    // Walks one accepted word through the buffer state; returns 1 with the
    // result when the word produces one.
    function automatic bit parse_word(input logic [31:0] word, input bit start,
                                      input logic [15:0] len, output t_result res);
        int unsigned pos;
        int unsigned avail;
        int unsigned payload;
        int unsigned minimum;
        bit          at_end;

        res = '0;
        if (start) begin
            buf_words  = t_offset'(len);
            cur_pos    = '0;
            skip_left  = '0;
            pkt_count  = '0;
            buf_failed = 1'b0;
            // empty buffer closes at once
            if (buf_words == 0) begin
                res.kind = KIND_DONE;
                return 1'b1;
            end
        end
        // after an error, or outside any buffer, words fall through silently
        if (buf_failed || cur_pos >= buf_words)
            return 1'b0;

        pos     = cur_pos;
        cur_pos = t_offset'(pos + 1);
        at_end  = (pos + 1 == buf_words);

        // payload word of an accepted packet
        if (skip_left != 0) begin
            skip_left = skip_left - 15'd1;
            if (at_end) begin
                res.kind           = KIND_DONE;
                res.packet_number  = pkt_count;
                res.consumed_words = buf_words;
                return 1'b1;
            end
            return 1'b0;
        end

        // header word
        res.header_value    = word;
        res.packet_opcode   = word[15:8];
        res.header_position = 16'(pos);
        res.packet_number   = pkt_count;
        if (word[31:30] != TYPE3) begin
            buf_failed         = 1'b1;
            res.kind           = KIND_ERR;
            res.err            = ERR_TYPE;
            res.consumed_words = 16'(pos);
            return 1'b1;
        end
        payload = word[29:16] + 1;
        avail   = buf_words - pos - 1;
        if (payload > avail) begin
            buf_failed           = 1'b1;
            res.kind             = KIND_ERR;
            res.err              = ERR_TRUNCATED;
            res.payload_length   = 15'(payload);
            res.available_length = 16'(avail);
            res.consumed_words   = 16'(pos);
            return 1'b1;
        end
        minimum = required_payload(word[15:8]);
        if (payload < minimum) begin
            buf_failed           = 1'b1;
            res.kind             = KIND_ERR;
            res.err              = ERR_SHORT;
            res.payload_length   = 15'(minimum);
            res.available_length = 16'(payload);
            res.consumed_words   = 16'(pos);
            return 1'b1;
        end
        res.kind             = KIND_PKT;
        res.payload_length   = 15'(payload);
        res.available_length = 16'(avail);
        skip_left            = 15'(payload);
        pkt_count            = pkt_count + 16'd1;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endfunction

    // Scoreboard: predicts on each accepted input request, checks each accepted
    // result request, and tracks register writes.
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;

        if (!i_rst_n) begin
            opcode_cfg = '{RST_SET_SH, RST_SET_CONTEXT, RST_SET_UCONFIG,
                           RST_DISPATCH_DIR, RST_DRAW_IDX};
            cur_pos    = '0;
            buf_words  = '0;
            skip_left  = '0;
            pkt_count  = '0;
            buf_failed = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_word(s_axis_tdata[31:0], s_axis_tuser, s_axis_tdata[47:32], want))
                    expected_results.insert(expected_results.size(), want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind             = t_kind'(m_axis_tuser);
                got.err              = t_err'(m_axis_tdata[1:0]);
                got.header_value     = m_axis_tdata[33:2];
                got.packet_opcode    = m_axis_tdata[41:34];
                got.header_position  = m_axis_tdata[57:42];
                got.packet_number    = m_axis_tdata[73:58];
                got.payload_length   = m_axis_tdata[88:74];
                got.available_length = m_axis_tdata[104:89];
                got.consumed_words   = m_axis_tdata[120:105];
                if (expected_results.size() == 0) begin
                    $error("result with none expected: kind %0d header %08h",
                           got.kind, got.header_value);
                    fault_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("error_code", want.err, got.err);
                    check_field("header_value", want.header_value, got.header_value);
                    check_field("packet_opcode", want.packet_opcode, got.packet_opcode);
                    check_field("header_position", want.header_position,
                                got.header_position);
                    check_field("packet_number", want.packet_number, got.packet_number);
                    check_field("payload_length", want.payload_length, got.payload_length);
                    check_field("available_length", want.available_length,
                                got.available_length);
                    check_field("consumed_words", want.consumed_words, got.consumed_words);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_SET_SH:          opcode_cfg.set_sh          = pwdata[7:0];
                    REG_SET_CONTEXT:     opcode_cfg.set_context     = pwdata[7:0];
                    REG_SET_UCONFIG:     opcode_cfg.set_uconfig     = pwdata[7:0];
                    REG_DISPATCH_DIRECT: opcode_cfg.dispatch_direct = pwdata[7:0];
                    REG_DRAW_INDEX_AUTO: opcode_cfg.draw_index_auto = pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------

    // Input side: offers the next queued word unless idling this cycle; a held
    // request stays up until taken.
    always @(posedge i_clk) begin : word_driver
        t_stream_word word_out;

        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                word_out = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {word_out.len, word_out.word};
                s_axis_tuser  <= word_out.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, plus a long hold-off whenever the sequence
    // bumps long_hold_req.
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_seen != long_hold_req) begin
            hold_seen     <= long_hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any request on any port resets the count.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_command_packet_stream_parser failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // buffer_length is only read on start words; elsewhere it carries noise.
    function automatic void push_word(input logic [31:0] word, input bit start,
                                      input logic [15:0] len);
        t_stream_word item;

        item = '{word, start, start ? len : 16'($urandom)};
        pending_words.insert(pending_words.size(), item);
        words_queued++;
    endfunction

    function automatic logic [31:0] make_header(input logic [1:0] ptype,
                                                input logic [13:0] count,
                                                input logic [7:0] op);
        return {ptype, count, op, 8'($urandom)};
    endfunction

    // Mostly one of the configured opcodes, else any value.
    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(7))
            0:       return opcode_cfg.set_sh;
            1:       return opcode_cfg.set_context;
            2:       return opcode_cfg.set_uconfig;
            3:       return opcode_cfg.dispatch_direct;
            4:       return opcode_cfg.draw_index_auto;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds one buffer of n_pkts packets, well formed except for the flaw.
    function automatic void push_buffer(input int n_pkts, input t_flaw flaw);
        logic [31:0] words[$];
        logic [7:0]  op;
        logic [1:0]  ptype;
        logic [13:0] count;
        int          need;
        int          body;
        int          keep;
        bit          final_pkt;
        logic [15:0] len;

        for (int p = 0; p < n_pkts; p++) begin
            final_pkt = (p == n_pkts - 1);
            op        = pick_opcode();
            need      = required_payload(op);
            body      = (need > 1) ? need + $urandom_range(0, 3) : $urandom_range(1, 6);
            ptype     = TYPE3;
            if (final_pkt && flaw == FLAW_TYPE)
                ptype = 2'($urandom_range(0, 2));
            if (final_pkt && flaw == FLAW_SHORT) begin
                op   = $urandom_range(1) ? opcode_cfg.dispatch_direct : opcode_cfg.set_context;
                need = required_payload(op);
                body = $urandom_range(1, need - 1);
            end
            count = 14'(body - 1);
            if (final_pkt && flaw == FLAW_TRUNC) begin
                // any count, followed by only a few words
                count = 14'($urandom);
                body  = $urandom_range(0, 3);
            end
            words.insert(words.size(), make_header(ptype, count, op));
            repeat (body) words.insert(words.size(), $urandom);
        end
        len = 16'(words.size());
        keep = words.size();
        if (flaw == FLAW_CUT)
            keep = $urandom_range(1, words.size() - 1);
        for (int i = 0; i < keep; i++)
            push_word(words[i], i == 0, len);
        if (flaw == FLAW_EXTRA)
            repeat ($urandom_range(1, 3)) push_word($urandom, 1'b0, '0);
    endfunction

    // Random traffic: mostly well-formed buffers, some broken, a few empty.
    function automatic void push_random_traffic(input int n_words);
        int first;
        int roll;

        first = words_queued;
        while (words_queued - first < n_words) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                push_word($urandom, 1'b1, '0);
                if ($urandom_range(1))
                    push_word($urandom, 1'b0, '0);
            end else if (roll < 70) begin
                push_buffer($urandom_range(1, 4), FLAW_NONE);
            end else begin
                push_buffer($urandom_range(1, 4), t_flaw'($urandom_range(FLAW_TYPE, FLAW_EXTRA)));
            end
        end
    endfunction

    // Blocks until every queued word is taken and every result has come back,
    // then lets silent words clear the pipeline.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle held until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_traffic(input int idle, input int stall);
        @(negedge i_clk);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        logic [7:0] shared_op;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset register values.
        // words before any buffer are ignored
        push_word(32'hFFFF_FFFF, 1'b0, '0);
        push_word(32'h0000_0000, 1'b0, '0);
        // empty buffer, then a stray word
        push_word($urandom, 1'b1, 16'd0);
        push_word($urandom, 1'b0, '0);
        // set_sh, dispatch_direct and draw_index_auto at their exact minimum; done on the last word
        push_word(make_header(TYPE3, 14'd1, opcode_cfg.set_sh), 1'b1, 16'd11);
        repeat (2) push_word($urandom, 1'b0, '0);
        push_word(make_header(TYPE3, 14'd3, opcode_cfg.dispatch_direct), 1'b0, '0);
        repeat (4) push_word($urandom, 1'b0, '0);
        push_word(make_header(TYPE3, 14'd1, opcode_cfg.draw_index_auto), 1'b0, '0);
        repeat (2) push_word($urandom, 1'b0, '0);
        push_buffer(1, FLAW_NONE);
        // unsupported type; the following word is dropped
        push_word(32'h0000_0000, 1'b1, 16'd3);
        push_word($urandom, 1'b0, '0);
        // dispatch one word short of its minimum
        push_word(make_header(TYPE3, 14'd2, opcode_cfg.dispatch_direct), 1'b1, 16'd5);
        // all-ones header in the longest buffer, then a restart mid-buffer
        push_word(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        push_word($urandom, 1'b0, '0);
        // header on the final word: truncation error, no done
        push_word(make_header(TYPE3, 14'd0, 8'($urandom)), 1'b1, 16'd1);
        // payload running past a short buffer
        push_word(make_header(TYPE3, 14'd5, 8'($urandom)), 1'b1, 16'd2);
        push_word($urandom, 1'b0, '0);
        wait_drained();

        // Random traffic with a long receiver hold-off up front so the block
        // backs up into its input.
        @(negedge i_clk);
        long_hold_req++;
        push_random_traffic(PHASE_WORDS / 2);
        // sender pauses until every result is back
        wait_drained();
        @(negedge i_clk);
        push_random_traffic(PHASE_WORDS / 2);
        wait_drained();

        // Extreme register values; several registers share 0 and 255.
        set_traffic(48, 0);
        write_reg(REG_SET_SH, 8'd0);
        write_reg(REG_SET_CONTEXT, 8'd255);
        write_reg(REG_SET_UCONFIG, 8'd0);
        write_reg(REG_DISPATCH_DIRECT, 8'd255);
        write_reg(REG_DRAW_INDEX_AUTO, 8'd0);
        @(negedge i_clk);
        push_random_traffic(PHASE_WORDS);
        wait_drained();

        // Dispatch shares its opcode with set_sh: the four-word minimum wins.
        set_traffic(0, 48);
        shared_op = 8'($urandom);
        write_reg(REG_SET_SH, shared_op);
        write_reg(REG_DISPATCH_DIRECT, shared_op);
        write_reg(REG_SET_CONTEXT, 8'($urandom));
        write_reg(REG_SET_UCONFIG, 8'($urandom));
        write_reg(REG_DRAW_INDEX_AUTO, 8'($urandom));
        @(negedge i_clk);
        push_random_traffic(PHASE_WORDS);
        wait_drained();

        // Random registers, both sides idling.
        set_traffic(18, 18);
        write_reg(REG_SET_SH, 8'($urandom));
        write_reg(REG_SET_CONTEXT, 8'($urandom));
        write_reg(REG_SET_UCONFIG, 8'($urandom));
        write_reg(REG_DISPATCH_DIRECT, 8'($urandom));
        write_reg(REG_DRAW_INDEX_AUTO, 8'($urandom));
        @(negedge i_clk);
        push_random_traffic(PHASE_WORDS);
        wait_drained();

        // Final drain with the receiver always ready, so a stray result shows up.
        set_traffic(0, 0);
        wait_drained();

        if (fault_count == 0)
            $display("tb_command_packet_stream_parser passed");
        else
            $display("tb_command_packet_stream_parser failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/cpsp_pkg.sv
src/cpsp_regs.sv
src/cpsp_core.sv
src/command_packet_stream_parser.sv
bench/tb_command_packet_stream_parser.sv
